@@ src/bbpos_pkg.sv @@
`timescale 1ns / 1ps

package bbpos_pkg;

    localparam int WINDOW_DEFAULT = 20;
    localparam int PRICE_W        = 24;
    localparam int POS_W          = 17;
    localparam int FRAC_W         = 16;
    localparam int BAND_MULT_W    = 3;
    localparam logic [BAND_MULT_W-1:0] BAND_MULT_RESET = 3'd2;
    localparam logic [POS_W-1:0]       POS_FULL        = 17'h10000;

    typedef struct packed {
        logic [PRICE_W-1:0] close_price;
        logic               series_start;
    } price_item_t;

    typedef struct packed {
        logic [POS_W-1:0] band_position;
        logic             position_valid;
    } band_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_OLD,
        ST_SQ_NEW,
        ST_ADD_NEW,
        ST_SQ_SUM,
        ST_DIFF,
        ST_ROOT,
        ST_SCALE,
        ST_FRAME,
        ST_CLAMP,
        ST_DIVIDE,
        ST_DONE
    } bbpos_state_t;

    typedef enum logic [1:0] {
        MUL_OLD_SQ,
        MUL_NEW_SQ,
        MUL_SUM_SQ,
        MUL_SCALE
    } bbpos_mul_sel_t;

endpackage

@@ src/bollinger_band_position_top.sv @@
`timescale 1ns / 1ps

// The result is computed by the bit-serial square root (SW steps, SW = 24 + clog2(WINDOW))
// and the 16-step divider.
// Items with too little history or a zero band multiplier skip the square root and divider.
// One item at a time: the next input transfer follows the result load, which waits while
// a result is stalled.
// Reset (rst_n, asynchronous): empty history, band_mult = 2, no result pending.
module bollinger_band_position_top #(
    parameter int WINDOW = bbpos_pkg::WINDOW_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   band_mult_wr_en,
    input  logic [bbpos_pkg::BAND_MULT_W-1:0]      band_mult_wr_data,
    input  logic                                   price_valid,
    output logic                                   price_stall,
    input  bbpos_pkg::price_item_t                 price_data,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output bbpos_pkg::band_item_t                  result_data
);
    import bbpos_pkg::*;

    localparam int LW  = $clog2(WINDOW);
    localparam int AW  = LW;
    localparam int SW  = PRICE_W + LW;
    localparam int QW  = 2 * PRICE_W + LW;
    localparam int DW  = 2 * SW;
    localparam int NW  = SW + 5;
    localparam int DNW = SW + 4;
    localparam int BW  = $clog2(WINDOW + 2);
    localparam int CW  = $clog2(SW);
    localparam int FCW = $clog2(FRAC_W);

    bbpos_state_t   state_reg, state_next;
    bbpos_mul_sel_t mul_sel;

    logic [PRICE_W-1:0]     price_ring [WINDOW];
    logic [PRICE_W-1:0]     old_price_reg;
    logic [PRICE_W-1:0]     price_reg;
    logic [AW-1:0]          write_slot_reg;
    logic [BW-1:0]          bars_reg;
    logic                   sub_old_reg;
    logic [SW-1:0]          sum_reg;
    logic [QW-1:0]          sq_sum_reg;
    logic [BAND_MULT_W-1:0] band_mult_reg;
    logic [DW-1:0]          prod_reg;
    logic [DW-1:0]          root_rem_reg;
    logic [DW-1:0]          root_res_reg;
    logic [DW-1:0]          root_bit_reg;
    logic [CW-1:0]          root_cnt_reg;
    logic [NW-1:0]          num_reg;
    logic [DNW-1:0]         den_reg;
    logic [DNW-1:0]         div_rem_reg;
    logic [FRAC_W-1:0]      quot_reg;
    logic [FCW-1:0]         div_cnt_reg;
    logic [POS_W-1:0]       pos_reg;
    logic                   valid_reg;
    logic                   result_valid_reg;
    band_item_t             result_data_reg;

    logic                   accept;
    logic                   out_free;
    logic [AW-1:0]          slot_eff;
    logic [BW-1:0]          bars_eff;
    logic [SW-1:0]          mul_a;
    logic [SW-1:0]          mul_b;
    logic [DW-1:0]          mul_p;
    logic [DW-1:0]          root_trial;
    logic                   root_take;
    logic [DNW:0]           div_shift;
    logic                   div_take;
    logic [FRAC_W-1:0]      quot_next;
    logic                   num_nonpos;
    logic                   num_over;
    logic                   history_ok;

    assign accept   = price_valid && !price_stall;
    assign out_free = !result_valid_reg || !result_stall;
    assign slot_eff = price_data.series_start ? '0 : write_slot_reg;
    assign bars_eff = price_data.series_start ? '0 : bars_reg;

    assign mul_p      = DW'(mul_a) * DW'(mul_b);
    assign root_trial = root_res_reg + root_bit_reg;
    assign root_take  = root_rem_reg >= root_trial;
    assign div_shift  = {div_rem_reg, 1'b0};
    assign div_take   = div_shift >= {1'b0, den_reg};
    assign quot_next  = {quot_reg[FRAC_W-2:0], div_take};
    assign num_nonpos = num_reg[NW-1] || (num_reg == '0);
    assign num_over   = num_reg[NW-2:0] >= den_reg;
    assign history_ok = (bars_reg == BW'(WINDOW + 1)) && (band_mult_reg != '0);

    assign result_valid = result_valid_reg;
    assign result_data  = result_data_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (price_valid)
                begin
                    state_next = ST_SQ_OLD;
                end
            end
            ST_SQ_OLD:  state_next = ST_SQ_NEW;
            ST_SQ_NEW:  state_next = ST_ADD_NEW;
            ST_ADD_NEW: state_next = history_ok ? ST_SQ_SUM : ST_DONE;
            ST_SQ_SUM:  state_next = ST_DIFF;
            ST_DIFF:    state_next = ST_ROOT;
            ST_ROOT:
            begin
                if (root_cnt_reg == '0)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:   state_next = (root_res_reg == '0) ? ST_DONE : ST_FRAME;
            ST_FRAME:   state_next = ST_CLAMP;
            ST_CLAMP:   state_next = (num_nonpos || num_over) ? ST_DONE : ST_DIVIDE;
            ST_DIVIDE:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: input stall and the shared multiplier operands.
    always_comb
    begin
        price_stall = (state_reg != ST_IDLE);
        mul_sel     = MUL_OLD_SQ;
        unique case (state_reg)
            ST_SQ_NEW: mul_sel = MUL_NEW_SQ;
            ST_SQ_SUM: mul_sel = MUL_SUM_SQ;
            ST_SCALE:  mul_sel = MUL_SCALE;
            default:   mul_sel = MUL_OLD_SQ;
        endcase
    end

    always_comb
    begin
        unique case (mul_sel)
            MUL_OLD_SQ:
            begin
                mul_a = SW'(old_price_reg);
                mul_b = SW'(old_price_reg);
            end
            MUL_NEW_SQ:
            begin
                mul_a = SW'(price_reg);
                mul_b = SW'(price_reg);
            end
            MUL_SUM_SQ:
            begin
                mul_a = sum_reg;
                mul_b = sum_reg;
            end
            default:
            begin
                mul_a = SW'(band_mult_reg);
                mul_b = root_res_reg[SW-1:0];
            end
        endcase
    end

    // Price history. The read returns the entry before this transfer overwrites it.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            old_price_reg        <= price_ring[slot_eff];
            price_ring[slot_eff] <= price_data.close_price;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            write_slot_reg   <= '0;
            bars_reg         <= '0;
            sum_reg          <= '0;
            sq_sum_reg       <= '0;
            band_mult_reg    <= BAND_MULT_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (band_mult_wr_en)
            begin
                band_mult_reg <= band_mult_wr_data;
            end
            if (accept)
            begin
                write_slot_reg <= (slot_eff == AW'(WINDOW - 1)) ? '0 : slot_eff + 1'b1;
                bars_reg       <= (bars_eff == BW'(WINDOW + 1)) ? bars_eff : bars_eff + 1'b1;
                if (price_data.series_start)
                begin
                    sum_reg    <= '0;
                    sq_sum_reg <= '0;
                end
            end
            if (state_reg == ST_SQ_NEW)
            begin
                sum_reg    <= sum_reg - (sub_old_reg ? SW'(old_price_reg) : '0)
                              + SW'(price_reg);
                sq_sum_reg <= sq_sum_reg - (sub_old_reg ? QW'(prod_reg) : '0);
            end
            if (state_reg == ST_ADD_NEW)
            begin
                sq_sum_reg <= sq_sum_reg + QW'(prod_reg);
            end
            if (state_reg == ST_DONE && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers of the products, numerator, square root and divider.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            price_reg   <= price_data.close_price;
            sub_old_reg <= (bars_eff >= BW'(WINDOW));
        end
        case (state_reg) inside
            ST_SQ_OLD, ST_SQ_NEW, ST_SQ_SUM:
            begin
                prod_reg <= mul_p;
            end
            ST_ADD_NEW:
            begin
                pos_reg   <= '0;
                valid_reg <= 1'b0;
            end
            ST_DIFF:
            begin
                root_rem_reg <= DW'(sq_sum_reg) * DW'(WINDOW) - prod_reg;
                root_res_reg <= '0;
                root_bit_reg <= DW'(1) << (DW - 2);
                root_cnt_reg <= CW'(SW - 1);
            end
            ST_ROOT:
            begin
                if (root_take)
                begin
                    root_rem_reg <= root_rem_reg - root_trial;
                    root_res_reg <= (root_res_reg >> 1) + root_bit_reg;
                end
                else
                begin
                    root_res_reg <= root_res_reg >> 1;
                end
                root_bit_reg <= root_bit_reg >> 2;
                root_cnt_reg <= root_cnt_reg - 1'b1;
            end
            ST_SCALE:
            begin
                prod_reg <= mul_p;
            end
            ST_FRAME:
            begin
                // Two's complement wrap keeps the sign of the numerator in the top bit.
                num_reg <= NW'(price_reg) * NW'(WINDOW) - NW'(sum_reg) + NW'(prod_reg);
                den_reg <= DNW'(prod_reg) << 1;
            end
            ST_CLAMP:
            begin
                valid_reg   <= 1'b1;
                div_rem_reg <= num_reg[DNW-1:0];
                quot_reg    <= '0;
                div_cnt_reg <= FCW'(FRAC_W - 1);
                if (num_nonpos)
                begin
                    pos_reg <= '0;
                end
                else if (num_over)
                begin
                    pos_reg <= POS_FULL;
                end
            end
            ST_DIVIDE:
            begin
                div_rem_reg <= div_take ? DNW'(div_shift - {1'b0, den_reg})
                                        : DNW'(div_shift);
                quot_reg    <= quot_next;
                div_cnt_reg <= div_cnt_reg - 1'b1;
                if (div_cnt_reg == '0)
                begin
                    pos_reg <= POS_W'(quot_next);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    result_data_reg.band_position  <= pos_reg;
                    result_data_reg.position_valid <= valid_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
